// ===== rtl/mswh_pkg.sv =====
`default_nettype none
package mswh_pkg;

   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH = 3;

   localparam logic [WORD_WIDTH-1:0] MIX_MULT   = 32'h5bd1e995;
   localparam int unsigned           FULL_SHIFT = 16;
   localparam int unsigned           TAIL_SHIFT = 24;

   localparam logic [COUNT_WIDTH-1:0] COUNT_EMPTY = 3'd0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = 3'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO   = 3'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_THREE = 3'd3;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]  word;
      logic [COUNT_WIDTH-1:0] count;
      logic                   last;
   } mswh_item_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] hash;
      logic                  finish;
   } mswh_mix_type;

endpackage
`default_nettype wire

// ===== rtl/mswh_mix.sv =====
`default_nettype none
module mswh_mix
   import mswh_pkg::*;
(
   input  wire mswh_item_type       item,
   input  wire [WORD_WIDTH-1:0]     hash,
   output mswh_mix_type             mix
);

   logic [WORD_WIDTH-1:0] addend;
   logic [WORD_WIDTH-1:0] sum;
   logic [WORD_WIDTH-1:0] prod;
   logic                  do_mix;
   logic                  tail;

   always_comb begin
      addend = item.word;
      do_mix = 1'b1;
      tail   = 1'b1;
      unique case (item.count)
         COUNT_EMPTY: begin
            do_mix = 1'b0;
            tail   = 1'b0;
         end
         COUNT_ONE:   addend = {24'd0, item.word[7:0]};
         COUNT_TWO:   addend = {16'd0, item.word[15:0]};
         COUNT_THREE: addend = {8'd0, item.word[23:0]};
         default:     tail   = 1'b0;
      endcase
   end

   assign sum  = hash + addend;
   assign prod = sum * MIX_MULT;

   always_comb begin
      if (!do_mix) begin
         mix.hash = hash;
      end else if (tail) begin
         mix.hash = prod ^ (prod >> TAIL_SHIFT);
      end else begin
         mix.hash = prod ^ (prod >> FULL_SHIFT);
      end
      mix.finish = item.last | tail;
   end

endmodule
`default_nettype wire

// ===== rtl/murmur_style_word_hash.sv =====
// MurmurHash1-style word hash with the MurmurHash2 multiplier, no seed, no final mix.
// Request channel (req_): one 32-bit little-endian message word per request
// with its byte count; req_tlast marks the end of the message. A word of one
// to three bytes also ends the message.
// Response channel (rsp_): one finished hash per message.
// A finished hash passes through the input register, loaded at the request
// edge, and then the result register, which drives the response.
// Throughput: one request per cycle unless a finished hash waits on a stalled
// receiver; the add, the 32x32 multiply and the xor-shift of one word sit
// between the input register and the running hash register.
// Reset zeroes the running hash and drops any request in flight or pending response.
// When the receiver stalls, the finished hash holds in the result register;
// words that do not end a message still advance, and the block stops taking
// requests only when a second finished hash would need the occupied register.
`default_nettype none
module murmur_style_word_hash
   import mswh_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // data_word[31:0], byte_count[34:32], zero[39:35]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata   // hash_value[31:0]
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   mswh_item_type         in_item_ff;
   logic [WORD_WIDTH-1:0] hash_ff;
   logic [WORD_WIDTH-1:0] hash_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [WORD_WIDTH-1:0] out_hash_ff;
   mswh_mix_type          mix;
   logic                  advance;
   logic                  out_load;
   logic                  req_take;

   mswh_mix u_mix (
      .item (in_item_ff),
      .hash (hash_ff),
      .mix  (mix)
   );

   assign advance    = in_valid_ff & (~mix.finish | ~out_valid_ff | rsp_tready);
   assign out_load   = advance & mix.finish;
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = out_load | (out_valid_ff & ~rsp_tready);

   always_comb begin
      hash_in = hash_ff;
      if (advance) begin
         hash_in = mix.finish ? '0 : mix.hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hash_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hash_ff      <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.word  <= req_tdata[WORD_WIDTH-1:0];
         in_item_ff.count <= req_tdata[WORD_WIDTH+COUNT_WIDTH-1:WORD_WIDTH];
         in_item_ff.last  <= req_tlast;
      end
      if (out_load) begin
         out_hash_ff <= mix.hash;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_hash_ff;

   a_hash_clear: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (hash_ff == '0))
      else $error("running hash not cleared after a finished message");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready && in_valid_ff && mix.finish) |-> !advance)
      else $error("pending hash overwritten while receiver stalls");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !in_valid_ff && hash_ff == '0))
      else $error("state not cleared by reset");

   a_hold_hash: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> $stable(hash_ff))
      else $error("running hash changed while the request held");

endmodule
`default_nettype wire
